[rtl/core/mh64_pkg.sv]
// ----------------------------------------------------------------------------
// MurmurHash64B package
// Shared constants, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package mh64_pkg;

    localparam logic [31:0] MIX_M      = 32'h5bd1_e995;
    localparam logic [31:0] SEED_RESET = 32'hEE6B_27EB;
    localparam int unsigned MIX_R      = 24;
    localparam int unsigned FIN_R1     = 18;
    localparam int unsigned FIN_R2     = 22;
    localparam int unsigned FIN_R3     = 17;
    localparam int unsigned FIN_R4     = 19;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_K2,
        OP_FOLD,
        OP_TAIL,
        OP_F1,
        OP_F2,
        OP_F3,
        OP_F4
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_full;
        logic in_tail;
        logic in_last;
        logic last;
    } t_dp_stat;

endpackage

[rtl/core/mh64_dpath.sv]
// ----------------------------------------------------------------------------
// MurmurHash64B datapath
// Hash halves, word register and one shared 32x32 multiplier (low product).
// ----------------------------------------------------------------------------
module mh64_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_seed,
    input  logic [31:0]           i_data_word,
    input  logic [2:0]            i_byte_count,
    input  logic                  i_last_word,
    input  logic [30:0]           i_message_length,
    input  mh64_pkg::t_dp_cmd     i_cmd,
    output mh64_pkg::t_dp_stat    o_stat,
    output logic [63:0]           o_hash_value
);

    logic [31:0] r_seed;
    logic [31:0] r_h1, n_h1;
    logic [31:0] r_h2, n_h2;
    logic [31:0] r_k,  n_k;
    logic        r_sel, n_sel;
    logic        r_in_msg, n_in_msg;
    logic        r_last, n_last;
    logic [63:0] r_hash, n_hash;

    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [31:0] in_mask;
    logic [31:0] h1_start;

    always_comb begin
        unique case (i_byte_count[1:0])
            2'd1:    in_mask = 32'h0000_00ff;
            2'd2:    in_mask = 32'h0000_ffff;
            2'd3:    in_mask = 32'h00ff_ffff;
            default: in_mask = 32'h0000_0000;
        endcase
    end

    assign o_stat.in_full = i_byte_count[2];
    assign o_stat.in_tail = !i_byte_count[2] && (i_byte_count[1:0] != 2'd0);
    assign o_stat.in_last = i_last_word;
    assign o_stat.last    = r_last;

    assign h1_start = r_seed ^ {1'b0, i_message_length};

    always_comb begin
        unique case (i_cmd.op)
            mh64_pkg::OP_LOAD: mul_a = i_data_word;
            mh64_pkg::OP_K2:   mul_a = r_k ^ (r_k >> mh64_pkg::MIX_R);
            mh64_pkg::OP_FOLD: mul_a = r_sel ? r_h2 : r_h1;
            mh64_pkg::OP_TAIL: mul_a = r_h2 ^ r_k;
            mh64_pkg::OP_F1:   mul_a = r_h1 ^ (r_h2 >> mh64_pkg::FIN_R1);
            mh64_pkg::OP_F2:   mul_a = r_h2 ^ (r_h1 >> mh64_pkg::FIN_R2);
            mh64_pkg::OP_F3:   mul_a = r_h1 ^ (r_h2 >> mh64_pkg::FIN_R3);
            mh64_pkg::OP_F4:   mul_a = r_h2 ^ (r_h1 >> mh64_pkg::FIN_R4);
            default:           mul_a = '0;
        endcase
    end

    assign prod = mul_a * mh64_pkg::MIX_M;

    always_comb begin
        n_h1     = r_h1;
        n_h2     = r_h2;
        n_k      = r_k;
        n_sel    = r_sel;
        n_in_msg = r_in_msg;
        n_last   = r_last;
        n_hash   = r_hash;
        unique case (i_cmd.op)
            mh64_pkg::OP_LOAD: begin
                if (!r_in_msg) begin
                    n_h1  = h1_start;
                    n_h2  = '0;
                    n_sel = 1'b0;
                end
                n_in_msg = 1'b1;
                n_last   = i_last_word;
                n_k      = i_byte_count[2] ? prod : (i_data_word & in_mask);
            end
            mh64_pkg::OP_K2: n_k = prod;
            mh64_pkg::OP_FOLD: begin
                if (r_sel) begin
                    n_h2 = prod ^ r_k;
                end else begin
                    n_h1 = prod ^ r_k;
                end
                n_sel = !r_sel;
            end
            mh64_pkg::OP_TAIL: n_h2 = prod;
            mh64_pkg::OP_F1:   n_h1 = prod;
            mh64_pkg::OP_F2:   n_h2 = prod;
            mh64_pkg::OP_F3:   n_h1 = prod;
            mh64_pkg::OP_F4: begin
                n_h2     = prod;
                n_hash   = {r_h1, prod};
                n_in_msg = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= mh64_pkg::SEED_RESET;
            r_sel    <= 1'b0;
            r_in_msg <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_seed;
            end
            r_sel    <= n_sel;
            r_in_msg <= n_in_msg;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h1   <= n_h1;
        r_h2   <= n_h2;
        r_k    <= n_k;
        r_hash <= n_hash;
    end

    assign o_hash_value = r_hash;

    a_fold_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == mh64_pkg::OP_FOLD) |=> (r_sel != $past(r_sel)))
        else $error("half select did not toggle after fold");

    a_fin_ends_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == mh64_pkg::OP_F4) |=> !r_in_msg)
        else $error("message still open after finalization");

    a_load_opens_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == mh64_pkg::OP_LOAD) |=> r_in_msg)
        else $error("message not open after load");

endmodule

[rtl/core/mh64_ctrl.sv]
// ----------------------------------------------------------------------------
// MurmurHash64B controller
// Sequences datapath operations per transaction and owns the output valid.
// ----------------------------------------------------------------------------
module mh64_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  mh64_pkg::t_dp_stat    i_stat,
    output mh64_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K2   = 3'd1;
    localparam logic [2:0] S_FOLD = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_F1   = 3'd4;
    localparam logic [2:0] S_F2   = 3'd5;
    localparam logic [2:0] S_F3   = 3'd6;
    localparam logic [2:0] S_F4   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = mh64_pkg::OP_NOP;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.op = mh64_pkg::OP_LOAD;
                    priority if (i_stat.in_full) begin
                        n_state = S_K2;
                    end else if (i_stat.in_tail) begin
                        n_state = S_TAIL;
                    end else if (i_stat.in_last) begin
                        n_state = S_F1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_K2: begin
                o_cmd.op = mh64_pkg::OP_K2;
                n_state  = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.op = mh64_pkg::OP_FOLD;
                n_state  = i_stat.last ? S_F1 : S_IDLE;
            end
            S_TAIL: begin
                o_cmd.op = mh64_pkg::OP_TAIL;
                n_state  = i_stat.last ? S_F1 : S_IDLE;
            end
            S_F1: begin
                o_cmd.op = mh64_pkg::OP_F1;
                n_state  = S_F2;
            end
            S_F2: begin
                o_cmd.op = mh64_pkg::OP_F2;
                n_state  = S_F3;
            end
            S_F3: begin
                o_cmd.op = mh64_pkg::OP_F3;
                n_state  = S_F4;
            end
            S_F4: begin
                if (out_free) begin
                    o_cmd.op    = mh64_pkg::OP_F4;
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_f4_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F4 && r_out_valid && i_out_stall) |=> (r_state == S_F4))
        else $error("finalization left while output held");

    a_empty_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_stat.in_full && !i_stat.in_tail && i_stat.in_last)
        |=> (r_state == S_F1))
        else $error("empty last transaction skipped finalization");

    a_result_from_f4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_F4))
        else $error("result raised outside finalization");

endmodule

[rtl/core/murmur_hash_64b_unit.sv]
// ----------------------------------------------------------------------------
// MurmurHash64B unit
// Streaming 64-bit MurmurHash64B over 32-bit little-endian message words.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   data_word, byte_count,
//                                                 last_word, message_length
//   out      output     o_out_valid / i_out_stall hash_value
//   cfg      input      i_cfg_valid / o_cfg_ready seed
//
// Full word: load, K2 and fold steps; short tail: load and tail steps;
// empty item: load step only. A last transaction adds steps F1 to F4.
// The steps share the single 32x32 multiplier, one product a cycle.
// Synchronous active-low reset; seed returns to 0xEE6B27EB.
// The result sits in an output register; a held result only stalls the next
// finalization.
// ----------------------------------------------------------------------------
module murmur_hash_64b_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic [30:0] i_message_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_seed
);

    mh64_pkg::t_dp_cmd  cmd;
    mh64_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mh64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mh64_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_seed       (i_cfg_seed),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_last_word      (i_last_word),
        .i_message_length (i_message_length),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_hash_value     (o_hash_value)
    );

endmodule
